[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);

`endif

[rtl/psfp_pkg.sv]
// Package for the particle sensor frame parser: frame layout constants,
// queue entry and result types, error codes. No dependencies.
package psfp_pkg;

  localparam int unsigned FRAME_LEN   = 32;
  localparam int unsigned POS_W       = $clog2(FRAME_LEN);
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned NUM_MASS    = 3;
  localparam int unsigned NUM_COUNT   = 6;

  localparam logic [7:0] START_BYTE = 8'h02;
  localparam logic [7:0] END_BYTE   = 8'h03;

  localparam logic [POS_W-1:0] HUNT_POS    = POS_W'(0);
  localparam logic [POS_W-1:0] MASS_FIRST  = POS_W'(1);
  localparam logic [POS_W-1:0] MASS_LAST   = POS_W'(12);
  localparam logic [POS_W-1:0] CNT_A_FIRST = POS_W'(13);
  localparam logic [POS_W-1:0] CNT_A_LAST  = POS_W'(18);
  localparam logic [POS_W-1:0] RSV_A_FIRST = POS_W'(19);
  localparam logic [POS_W-1:0] RSV_A_LAST  = POS_W'(20);
  localparam logic [POS_W-1:0] CNT_B_FIRST = POS_W'(21);
  localparam logic [POS_W-1:0] CNT_B_LAST  = POS_W'(26);
  localparam logic [POS_W-1:0] RSV_B_FIRST = POS_W'(27);
  localparam logic [POS_W-1:0] RSV_B_LAST  = POS_W'(28);
  localparam logic [POS_W-1:0] STATUS_POS  = POS_W'(29);
  localparam logic [POS_W-1:0] CHECK_POS   = POS_W'(30);
  localparam logic [POS_W-1:0] LAST_POS    = POS_W'(FRAME_LEN - 1);

  localparam logic [2:0] CNT_B_BASE = 3'(NUM_COUNT / 2);

  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_RESERVED = 2'd1,
    ERR_CHECKSUM = 2'd2,
    ERR_END      = 2'd3
  } frame_err_e;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [7:0]       data;
  } psfp_entry_t;

  typedef struct packed {
    logic [31:0] mass_pm1;
    logic [31:0] mass_pm25;
    logic [31:0] mass_pm10;
    logic [15:0] count_0p5;
    logic [15:0] count_1p0;
    logic [15:0] count_2p5;
    logic [15:0] count_5p0;
    logic [15:0] count_7p5;
    logic [15:0] count_10;
    logic [7:0]  sensor_status;
    frame_err_e  frame_error;
  } psfp_result_t;

endpackage

[rtl/psfp_rx_if.sv]
// Valid/ready channel carrying one received serial byte.
// No dependencies.
interface psfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

[rtl/psfp_res_if.sv]
// Valid/ready channel carrying one decoded sensor frame.
// No dependencies.
interface psfp_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] mass_pm1;
  logic [31:0] mass_pm25;
  logic [31:0] mass_pm10;
  logic [15:0] count_0p5;
  logic [15:0] count_1p0;
  logic [15:0] count_2p5;
  logic [15:0] count_5p0;
  logic [15:0] count_7p5;
  logic [15:0] count_10;
  logic [7:0]  sensor_status;
  logic [1:0]  frame_error;

  modport source (
    output valid, output mass_pm1, output mass_pm25, output mass_pm10,
    output count_0p5, output count_1p0, output count_2p5, output count_5p0,
    output count_7p5, output count_10, output sensor_status, output frame_error,
    input ready
  );
  modport sink (
    input valid, input mass_pm1, input mass_pm25, input mass_pm10,
    input count_0p5, input count_1p0, input count_2p5, input count_5p0,
    input count_7p5, input count_10, input sensor_status, input frame_error,
    output ready
  );
endinterface

[rtl/psfp_fifo.sv]
// Short queue of classified bytes between front and back.
// Depends on psfp_pkg.
module psfp_fifo import psfp_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  psfp_entry_t entry_i,
  output logic        full_o,
  output logic        valid_o,
  output psfp_entry_t entry_o,
  input  logic        pop_i
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  psfp_entry_t         mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

[rtl/psfp_front.sv]
// Front end: accepts bytes, tracks frame position, drops all but a start byte while hunting.
// Depends on psfp_pkg and psfp_rx_if.
module psfp_front import psfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  psfp_rx_if.sink     rx_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output psfp_entry_t q_entry_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic             accept;
  logic             hunting;

  assign rx_i.ready = !q_full_i;
  assign accept     = rx_i.valid && !q_full_i;
  assign hunting    = (pos_q == HUNT_POS);

  // drop anything but a start byte while hunting
  assign q_push_o       = accept && (!hunting || (rx_i.rx_byte == START_BYTE));
  assign q_entry_o.pos  = pos_q;
  assign q_entry_o.data = rx_i.rx_byte;

  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      if (hunting) begin
        pos_d = (rx_i.rx_byte == START_BYTE) ? MASS_FIRST : HUNT_POS;
      end else begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= HUNT_POS;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

[rtl/psfp_back.sv]
// Back end: assembles frame fields, checks the frame, holds the result.
// Depends on psfp_pkg and psfp_res_if.
module psfp_back import psfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  psfp_entry_t q_entry_i,
  output logic        q_pop_o,
  psfp_res_if.source  res_o
);

  logic [31:0]  mass_q [NUM_MASS];
  logic [15:0]  count_q [NUM_COUNT];
  logic [7:0]   status_q;
  logic [7:0]   check_q;
  logic [7:0]   xor_q;
  logic         rbad_q;
  logic         out_valid_q;
  psfp_result_t result_q, result_d;

  logic             load_ok;
  logic             is_last;
  logic             take;
  logic [POS_W-1:0] off_mass;
  logic [POS_W-1:0] off_cnt_a;
  logic [POS_W-1:0] off_cnt_b;
  logic [2:0]       cnt_idx;
  logic             cnt_lane;
  frame_err_e       err;

  assign load_ok = !out_valid_q || res_o.ready;
  assign is_last = (q_entry_i.pos == LAST_POS);
  assign q_pop_o = q_valid_i && (!is_last || load_ok);
  assign take    = q_pop_o;

  assign off_mass  = q_entry_i.pos - MASS_FIRST;
  assign off_cnt_a = q_entry_i.pos - CNT_A_FIRST;
  assign off_cnt_b = q_entry_i.pos - CNT_B_FIRST;

  always_comb begin
    if (q_entry_i.pos >= CNT_B_FIRST) begin
      cnt_idx  = CNT_B_BASE + {1'b0, off_cnt_b[2:1]};
      cnt_lane = off_cnt_b[0];
    end else begin
      cnt_idx  = {1'b0, off_cnt_a[2:1]};
      cnt_lane = off_cnt_a[0];
    end
  end

  always_comb begin
    if (rbad_q) begin
      err = ERR_RESERVED;
    end else if (check_q != xor_q) begin
      err = ERR_CHECKSUM;
    end else if (q_entry_i.data != END_BYTE) begin
      err = ERR_END;
    end else begin
      err = ERR_OK;
    end
  end

  always_comb begin
    result_d.mass_pm1      = mass_q[0];
    result_d.mass_pm25     = mass_q[1];
    result_d.mass_pm10     = mass_q[2];
    result_d.count_0p5     = count_q[0];
    result_d.count_1p0     = count_q[1];
    result_d.count_2p5     = count_q[2];
    result_d.count_5p0     = count_q[3];
    result_d.count_7p5     = count_q[4];
    result_d.count_10      = count_q[5];
    result_d.sensor_status = status_q;
    result_d.frame_error   = err;
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      if (q_entry_i.pos != HUNT_POS && q_entry_i.pos <= STATUS_POS) begin
        xor_q <= xor_q ^ q_entry_i.data;
      end
      unique case (q_entry_i.pos) inside
        HUNT_POS: begin
          xor_q  <= '0;
          rbad_q <= 1'b0;
        end
        [MASS_FIRST:MASS_LAST]: begin
          mass_q[off_mass[3:2]][{off_mass[1:0], 3'b000} +: 8] <= q_entry_i.data;
        end
        [CNT_A_FIRST:CNT_A_LAST], [CNT_B_FIRST:CNT_B_LAST]: begin
          count_q[cnt_idx][{cnt_lane, 3'b000} +: 8] <= q_entry_i.data;
        end
        [RSV_A_FIRST:RSV_A_LAST], [RSV_B_FIRST:RSV_B_LAST]: begin
          if (q_entry_i.data != 8'h00) begin
            rbad_q <= 1'b1;
          end
        end
        STATUS_POS: status_q <= q_entry_i.data;
        CHECK_POS:  check_q  <= q_entry_i.data;
        default: begin
          if (is_last) begin
            result_q <= result_d;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take && is_last) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.mass_pm1      = result_q.mass_pm1;
  assign res_o.mass_pm25     = result_q.mass_pm25;
  assign res_o.mass_pm10     = result_q.mass_pm10;
  assign res_o.count_0p5     = result_q.count_0p5;
  assign res_o.count_1p0     = result_q.count_1p0;
  assign res_o.count_2p5     = result_q.count_2p5;
  assign res_o.count_5p0     = result_q.count_5p0;
  assign res_o.count_7p5     = result_q.count_7p5;
  assign res_o.count_10      = result_q.count_10;
  assign res_o.sensor_status = result_q.sensor_status;
  assign res_o.frame_error   = result_q.frame_error;

endmodule

[rtl/particle_sensor_frame_parser_core.sv]
// Throughput: one byte per cycle; ready drops only when the byte queue is full.
// Result path: an accepted end byte is written to the queue, then popped by the back end
// into the result register, which raises valid; the pop waits while an earlier result is held and not taken.
// Reset: asynchronous, active low; clears frame position, queue and result valid,
// so the parser restarts hunting for a start byte.
module particle_sensor_frame_parser_core import psfp_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  psfp_rx_if.sink    rx_i,
  psfp_res_if.source res_o
);

  logic        q_push;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  psfp_entry_t q_wr_entry;
  psfp_entry_t q_rd_entry;

  psfp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_i      (rx_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_entry_o (q_wr_entry)
  );

  psfp_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_wr_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (q_rd_entry),
    .pop_i   (q_pop)
  );

  psfp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_entry_i (q_rd_entry),
    .q_pop_o   (q_pop),
    .res_o     (res_o)
  );

endmodule

[rtl/psfp_checker.sv]
// Port-level checker for the frame parser, bound to the top level.
// Depends on psfp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module psfp_checker import psfp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rx_valid_i,
  input logic        rx_ready_i,
  input logic [7:0]  rx_byte_i,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [31:0] mass_pm1_i,
  input logic [7:0]  status_i,
  input logic [1:0]  err_i
);

  logic [POS_W-1:0] pos_q;
  logic [2:0]       pend_q;
  logic             rx_xfer;
  logic             res_xfer;
  logic             done;

  assign rx_xfer  = rx_valid_i && rx_ready_i;
  assign res_xfer = res_valid_i && res_ready_i;
  assign done     = rx_xfer && (pos_q == LAST_POS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= HUNT_POS;
      pend_q <= '0;
    end else begin
      if (rx_xfer) begin
        if (pos_q == HUNT_POS) begin
          pos_q <= (rx_byte_i == START_BYTE) ? MASS_FIRST : HUNT_POS;
        end else begin
          pos_q <= pos_q + 1'b1;
        end
      end
      pend_q <= pend_q + {2'b00, done} - {2'b00, res_xfer};
    end
  end

  `ASSERT_NEVER(a_no_unframed_result, clk_i, rst_ni,
                res_xfer && (pend_q == '0),
                "result without a completed frame")
  `ASSERT_CLK(a_res_valid_hold, clk_i, rst_ni,
              res_valid_i && !res_ready_i |=> res_valid_i,
              "result valid dropped before transfer")
  `ASSERT_CLK(a_res_data_hold, clk_i, rst_ni,
              res_valid_i && !res_ready_i |=>
                $stable(mass_pm1_i) && $stable(status_i) && $stable(err_i),
              "stalled result changed")

endmodule

bind particle_sensor_frame_parser_core psfp_checker u_psfp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rx_valid_i  (rx_i.valid),
  .rx_ready_i  (rx_i.ready),
  .rx_byte_i   (rx_i.rx_byte),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .mass_pm1_i  (res_o.mass_pm1),
  .status_i    (res_o.sensor_status),
  .err_i       (res_o.frame_error)
);

[tb/sv/particle_sensor_frame_parser_core_tb.sv]
// Testbench for particle_sensor_frame_parser_core: drives serial bytes and whole sensor
// frames, predicts every decoded frame and checks each result transfer field by field.
// Depends on psfp_pkg, psfp_rx_if and psfp_res_if.
module particle_sensor_frame_parser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import psfp_pkg::*;

  typedef logic [7:0] frame_bytes_t [FRAME_LEN];

  class frame_scoreboard;
    logic [POS_W-1:0] pos;
    logic [7:0]       xor_acc;
    logic [7:0]       status;
    logic [7:0]       check;
    logic             rsv_bad;
    logic [31:0]      mass_acc [NUM_MASS];
    logic [15:0]      count_acc [NUM_COUNT];
    psfp_result_t     frames_due [$];
    int unsigned      mismatches;
    int unsigned      frames_predicted;

    function new();
      pos = HUNT_POS;
      xor_acc = '0;
      status = '0;
      check = '0;
      rsv_bad = 1'b0;
      foreach (mass_acc[i]) mass_acc[i] = '0;
      foreach (count_acc[i]) count_acc[i] = '0;
      mismatches = 0;
      frames_predicted = 0;
    endfunction

    function int unsigned pending();
      return frames_due.size();
    endfunction

    function void decode_byte(logic [7:0] b);
      int unsigned  idx;
      psfp_result_t frame;
      if (pos == HUNT_POS) begin
        if (b == START_BYTE) begin
          pos = MASS_FIRST;
          xor_acc = '0;
          rsv_bad = 1'b0;
        end
        return;
      end
      if (pos != LAST_POS) begin
        if (pos <= STATUS_POS) xor_acc ^= b;
        if (pos <= MASS_LAST) begin
          idx = pos - MASS_FIRST;
          mass_acc[idx / 4][8 * (idx % 4) +: 8] = b;
        end else if (pos >= CNT_A_FIRST && pos <= CNT_A_LAST) begin
          idx = pos - CNT_A_FIRST;
          count_acc[idx / 2][8 * (idx % 2) +: 8] = b;
        end else if (pos >= CNT_B_FIRST && pos <= CNT_B_LAST) begin
          idx = pos - CNT_B_FIRST;
          count_acc[CNT_B_BASE + idx / 2][8 * (idx % 2) +: 8] = b;
        end else if ((pos >= RSV_A_FIRST && pos <= RSV_A_LAST) ||
                     (pos >= RSV_B_FIRST && pos <= RSV_B_LAST)) begin
          if (b != 8'h00) rsv_bad = 1'b1;
        end else if (pos == STATUS_POS) begin
          status = b;
        end else if (pos == CHECK_POS) begin
          check = b;
        end
        pos = pos + 1'b1;
        return;
      end
      frame.mass_pm1      = mass_acc[0];
      frame.mass_pm25     = mass_acc[1];
      frame.mass_pm10     = mass_acc[2];
      frame.count_0p5     = count_acc[0];
      frame.count_1p0     = count_acc[1];
      frame.count_2p5     = count_acc[2];
      frame.count_5p0     = count_acc[3];
      frame.count_7p5     = count_acc[4];
      frame.count_10      = count_acc[5];
      frame.sensor_status = status;
      if (rsv_bad) frame.frame_error = ERR_RESERVED;
      else if (check != xor_acc) frame.frame_error = ERR_CHECKSUM;
      else if (b != END_BYTE) frame.frame_error = ERR_END;
      else frame.frame_error = ERR_OK;
      frames_due.push_back(frame);
      frames_predicted++;
      pos = HUNT_POS;
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        $error("%s: expected %0h, got %0h", name, want, seen);
        mismatches++;
      end
    endfunction

    function void check_frame(psfp_result_t got);
      psfp_result_t want;
      if (frames_due.size() == 0) begin
        $error("frame: expected none, got %0h", got);
        mismatches++;
        return;
      end
      want = frames_due.pop_front();
      cmp_field("mass_pm1", want.mass_pm1, got.mass_pm1);
      cmp_field("mass_pm25", want.mass_pm25, got.mass_pm25);
      cmp_field("mass_pm10", want.mass_pm10, got.mass_pm10);
      cmp_field("count_0p5", want.count_0p5, got.count_0p5);
      cmp_field("count_1p0", want.count_1p0, got.count_1p0);
      cmp_field("count_2p5", want.count_2p5, got.count_2p5);
      cmp_field("count_5p0", want.count_5p0, got.count_5p0);
      cmp_field("count_7p5", want.count_7p5, got.count_7p5);
      cmp_field("count_10", want.count_10, got.count_10);
      cmp_field("sensor_status", want.sensor_status, got.sensor_status);
      cmp_field("frame_error", want.frame_error, got.frame_error);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   src_gaps;
  bit   sink_stalls;

  int unsigned frame_bytes_sent;

  frame_scoreboard frame_sb = new();

  psfp_rx_if  rx_if ();
  psfp_res_if res_if ();

  particle_sensor_frame_parser_core i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    res_if.ready <= !sink_stalls || ($urandom_range(99) >= 33);
  end

  always @(posedge clk) begin : watch_transfers
    psfp_result_t got;
    if (rst_n && rx_if.valid && rx_if.ready) frame_sb.decode_byte(rx_if.rx_byte);
    if (rst_n && res_if.valid && res_if.ready) begin
      got = '{res_if.mass_pm1, res_if.mass_pm25, res_if.mass_pm10,
              res_if.count_0p5, res_if.count_1p0, res_if.count_2p5,
              res_if.count_5p0, res_if.count_7p5, res_if.count_10,
              res_if.sensor_status, frame_err_e'(res_if.frame_error)};
      frame_sb.check_frame(got);
    end
  end

  function automatic frame_bytes_t make_frame(logic [7:0] fill, bit rnd);
    frame_bytes_t f;
    logic [7:0]   acc;
    acc = '0;
    foreach (f[i]) f[i] = rnd ? 8'($urandom) : fill;
    f[HUNT_POS] = START_BYTE;
    f[RSV_A_FIRST] = '0;
    f[RSV_A_LAST] = '0;
    f[RSV_B_FIRST] = '0;
    f[RSV_B_LAST] = '0;
    for (int i = MASS_FIRST; i <= STATUS_POS; i++) acc ^= f[i];
    f[CHECK_POS] = acc;
    f[LAST_POS] = END_BYTE;
    return f;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while (src_gaps && $urandom_range(99) < 33) begin
      rx_if.valid <= 1'b0;
      rx_if.rx_byte <= 8'($urandom);
      @(posedge clk);
    end
    rx_if.valid <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (!rx_if.ready);
  endtask

  task automatic send_frame(input frame_bytes_t f, input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(f[i]);
      frame_bytes_sent++;
    end
  endtask

  task automatic send_noise(input int unsigned len);
    repeat (len) send_byte(8'($urandom));
  endtask

  task automatic send_directed();
    frame_bytes_t f;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(END_BYTE);
    send_byte(8'h55);
    send_frame(make_frame(8'hFF, 1'b0), FRAME_LEN);
    send_frame(make_frame(8'h00, 1'b0), FRAME_LEN);
    send_frame(make_frame(START_BYTE, 1'b0), FRAME_LEN);
    f = make_frame('0, 1'b1);
    f[RSV_B_LAST] = 8'h80;
    f[CHECK_POS] ^= 8'h01;
    f[LAST_POS] = 8'hFF;
    send_frame(f, FRAME_LEN);
    f = make_frame('0, 1'b1);
    f[CHECK_POS] ^= 8'hFF;
    f[LAST_POS] = 8'h00;
    send_frame(f, FRAME_LEN);
    f = make_frame('0, 1'b1);
    f[LAST_POS] = START_BYTE;
    send_frame(f, FRAME_LEN);
  endtask

  task automatic send_random();
    frame_bytes_t f;
    int unsigned  roll;
    int unsigned  frame_no;
    frame_no = 0;
    while (frame_bytes_sent < 1300 || frame_sb.frames_predicted < 48) begin
      src_gaps = !(frame_no >= 12 && frame_no < 22);
      sink_stalls = src_gaps;
      if ($urandom_range(99) < 15) begin
        send_noise($urandom_range(1, 6));
        continue;
      end
      f = make_frame('0, 1'b1);
      roll = $urandom_range(99);
      if ($urandom_range(9) == 0) begin
        f[$urandom_range(MASS_FIRST, STATUS_POS)] = START_BYTE;
        f = make_frame_keep(f);
      end
      if (roll < 12 || (roll >= 34 && roll < 40)) begin
        case ($urandom_range(3))
          0: f[RSV_A_FIRST] = 8'($urandom_range(1, 255));
          1: f[RSV_A_LAST] = 8'($urandom_range(1, 255));
          2: f[RSV_B_FIRST] = 8'($urandom_range(1, 255));
          default: f[RSV_B_LAST] = 8'($urandom_range(1, 255));
        endcase
      end
      if ((roll >= 12 && roll < 24) || (roll >= 34 && roll < 40))
        f[CHECK_POS] ^= 8'($urandom_range(1, 255));
      if (roll >= 24 && roll < 40) f[LAST_POS] = END_BYTE ^ 8'($urandom_range(1, 255));
      if (roll >= 40 && roll < 45) send_frame(f, $urandom_range(1, FRAME_LEN - 1));
      else send_frame(f, FRAME_LEN);
      frame_no++;
    end
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
  endtask

  function automatic frame_bytes_t make_frame_keep(frame_bytes_t f);
    logic [7:0] acc;
    acc = '0;
    for (int i = MASS_FIRST; i <= STATUS_POS; i++) acc ^= f[i];
    f[CHECK_POS] = acc;
    return f;
  endfunction

  initial begin
    rst_n = 1'b0;
    rx_if.valid = 1'b0;
    rx_if.rx_byte = '0;
    res_if.ready = 1'b0;
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
    frame_bytes_sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_directed();
    send_random();
    rx_if.valid <= 1'b0;
    while (frame_sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (frame_sb.mismatches == 0 && frame_sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
